// File: hw/rtl/nvn_pkg.sv
package nvn_pkg;

    typedef enum logic [2:0] {
        OP_LOAD_CH  = 3'd0,
        OP_LOAD_MSG = 3'd1,
        OP_EMIT     = 3'd2,
        OP_DECIDE   = 3'd3,
        OP_READ     = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_OUT
    } state_t;

    localparam int unsigned CFG_DEGREE = 0;
    localparam int unsigned CFG_FIELD  = 1;
    localparam int unsigned CFG_LIST   = 2;

    localparam int unsigned LLR_W = 21;

    // effective register values after saturation, sized for the widest parameters
    typedef struct packed {
        logic [5:0] degree;
        logic [8:0] field;
        logic [6:0] list;
    } eff_cfg_t;

    typedef struct packed {
        logic       accept;
        logic [2:0] op;
        logic       clear;
        logic       rd_en;
        logic       skip;
        logic       first;
        logic       last;
        logic [8:0] q;
        logic [4:0] e;
        logic       load_out;
        logic [5:0] k;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic m_valid;
    } status_t;

endpackage

// File: hw/rtl/nonbinary_ldpc_variable_node_unit.sv
// emit edge list and decide: field_size * degree_in_use edge reads walking the message ram
// (one edge read per cycle), then the pipeline drains and the result beats are sent
// read posterior: degree_in_use edge reads to its single result; loads finish at acceptance
// one item at a time; the next item is taken once the last result sits in the output register
// aresetn (synchronous, active low) clears control and sets registers to 4, 64, 4;
// ram contents are undefined until written
module nonbinary_ldpc_variable_node_unit #(
    parameter int unsigned MAX_DEGREE = 16,
    parameter int unsigned MAX_FIELD  = 64,
    parameter int unsigned MAX_LIST   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [3:0]  s_edge_req,
    input  logic [5:0]  s_symbol,
    input  logic signed [15:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_out_symbol,
    output logic signed [20:0] m_out_llr,
    output logic        m_last
);

    logic [4:0] degree_reg;
    logic [6:0] field_reg;
    logic [4:0] list_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= 5'd4;
            field_reg  <= 7'd64;
            list_reg   <= 5'd4;
        end else if (cfg_we) begin
            case (32'(cfg_index))
                nvn_pkg::CFG_DEGREE: degree_reg <= cfg_wdata[4:0];
                nvn_pkg::CFG_FIELD:  field_reg  <= cfg_wdata;
                nvn_pkg::CFG_LIST:   list_reg   <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    nvn_pkg::eff_cfg_t eff;

    always_comb begin
        int unsigned d, f, n;
        d = 32'(degree_reg);
        f = 32'(field_reg);
        n = 32'(list_reg);
        if (d < 1) d = 1;
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        if (f < 2) f = 2;
        if (f > MAX_FIELD) f = MAX_FIELD;
        if (n < 1) n = 1;
        if (n > MAX_LIST) n = MAX_LIST;
        if (n > f) n = f;
        eff.degree = 6'(d);
        eff.field  = 9'(f);
        eff.list   = 7'(n);
    end

    nvn_pkg::cmd_t    cmd;
    nvn_pkg::status_t status;

    nvn_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .eff      (eff),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_symbol (s_symbol),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    nvn_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .MAX_FIELD  (MAX_FIELD),
        .MAX_LIST   (MAX_LIST)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .eff          (eff),
        .s_edge_req   (s_edge_req),
        .s_symbol     (s_symbol),
        .s_value      (s_value),
        .m_out_symbol (m_out_symbol),
        .m_out_llr    (m_out_llr),
        .m_last       (m_last)
    );

    assign m_valid = status.m_valid;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> !s_ready)
        else $error("input ready while a walk is in progress");

    a_emit_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == nvn_pkg::OP_EMIT) |=> status.busy)
        else $error("emit beat did not start a walk");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_llr) && $stable(m_last)))
        else $error("result beat changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("reset did not clear the handshake state");

endmodule

// File: hw/rtl/nvn_ram.sv
module nvn_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/nvn_controller.sv
module nvn_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  nvn_pkg::eff_cfg_t eff,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_opcode,
    input  logic [5:0]        s_symbol,
    input  logic              m_ready,
    output nvn_pkg::cmd_t     cmd,
    output nvn_pkg::status_t status
);

    nvn_pkg::state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [8:0] q_reg, q_next;
    logic [4:0] j_reg, j_next;
    logic       cnt_reg, cnt_next;
    logic [5:0] k_reg, k_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       j_last;
    logic       q_last;
    logic       out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nvn_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            op_reg      <= 3'd0;
            q_reg       <= 9'd0;
            j_reg       <= 5'd0;
            cnt_reg     <= 1'b0;
            k_reg       <= 6'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            op_reg      <= op_next;
            q_reg       <= q_next;
            j_reg       <= j_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
        end
    end

    assign accept   = s_valid && s_ready;
    assign j_last   = ({1'b0, j_reg} == eff.degree - 6'd1);
    assign q_last   = (op_reg == nvn_pkg::OP_READ) || (q_reg == eff.field - 9'd1);
    assign out_last = (op_reg != nvn_pkg::OP_EMIT) || ({1'b0, k_reg} == eff.list - 7'd1);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        q_next       = q_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.q        = q_reg;
        cmd.e        = j_reg;
        cmd.k        = k_reg;
        cmd.out_last = out_last;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            nvn_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = accept;
                cmd.op     = s_opcode;
                if (accept) begin
                    op_next = s_opcode;
                    j_next  = 5'd0;
                    k_next  = 6'd0;
                    q_next  = (s_opcode == nvn_pkg::OP_READ) ? {3'd0, s_symbol} : 9'd0;
                    case (s_opcode)
                        nvn_pkg::OP_EMIT, nvn_pkg::OP_DECIDE, nvn_pkg::OP_READ: begin
                            state_next = nvn_pkg::ST_WALK;
                            cmd.clear  = 1'b1;
                        end
                        default: state_next = nvn_pkg::ST_IDLE;
                    endcase
                end
            end
            nvn_pkg::ST_WALK: begin
                cmd.rd_en = 1'b1;
                cmd.skip  = (op_reg == nvn_pkg::OP_EMIT);
                cmd.first = (j_reg == 5'd0);
                cmd.last  = j_last;
                if (j_last) begin
                    j_next = 5'd0;
                    q_next = q_reg + 9'd1;
                    if (q_last) begin
                        state_next = nvn_pkg::ST_DRAIN;
                        cnt_next   = 1'b0;
                    end
                end else begin
                    j_next = j_reg + 5'd1;
                end
            end
            nvn_pkg::ST_DRAIN: begin
                // ram read and accumulate stages still in flight
                cnt_next = 1'b1;
                if (cnt_reg) begin
                    state_next = nvn_pkg::ST_OUT;
                end
            end
            nvn_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    k_next       = k_reg + 6'd1;
                    if (out_last) begin
                        state_next = nvn_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = nvn_pkg::ST_IDLE;
        endcase
    end

    assign status.busy    = (state_reg != nvn_pkg::ST_IDLE);
    assign status.m_valid = m_valid_reg;

endmodule

// File: hw/rtl/nvn_datapath.sv
module nvn_datapath #(
    parameter int unsigned MAX_DEGREE = 16,
    parameter int unsigned MAX_FIELD  = 64,
    parameter int unsigned MAX_LIST   = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  nvn_pkg::cmd_t            cmd,
    input  nvn_pkg::eff_cfg_t        eff,
    input  logic [3:0]               s_edge_req,
    input  logic [5:0]               s_symbol,
    input  logic signed [15:0]       s_value,
    output logic [5:0]               m_out_symbol,
    output logic signed [nvn_pkg::LLR_W-1:0] m_out_llr,
    output logic                     m_last
);

    localparam int unsigned FW = $clog2(MAX_FIELD);
    localparam int unsigned DW = $clog2(MAX_DEGREE);
    localparam int unsigned SW = 16 + $clog2(MAX_DEGREE + 1);
    localparam int unsigned LW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;

    logic [3:0]  edge_reg;
    logic [5:0]  sym_reg;
    logic        sym_ok;
    logic        edge_ok;
    logic        ch_we, msg_we;
    logic [15:0] ch_rdata, msg_rdata;

    assign sym_ok  = (32'(s_symbol) < MAX_FIELD);
    assign edge_ok = (32'(s_edge_req) < MAX_DEGREE);
    assign ch_we   = cmd.accept && (cmd.op == nvn_pkg::OP_LOAD_CH) && sym_ok;
    assign msg_we  = cmd.accept && (cmd.op == nvn_pkg::OP_LOAD_MSG) && sym_ok && edge_ok;

    nvn_ram #(.WIDTH(16), .DEPTH(MAX_FIELD)) u_ch_ram (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr (FW'(s_symbol)),
        .wdata (s_value),
        .raddr (cmd.q[FW-1:0]),
        .rdata (ch_rdata)
    );

    nvn_ram #(.WIDTH(16), .DEPTH(2 ** (DW + FW))) u_msg_ram (
        .aclk  (aclk),
        .we    (msg_we),
        .waddr ({DW'(s_edge_req), FW'(s_symbol)}),
        .wdata (s_value),
        .raddr ({cmd.e[DW-1:0], cmd.q[FW-1:0]}),
        .rdata (msg_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            edge_reg <= s_edge_req;
            sym_reg  <= s_symbol;
        end
    end

    // stage 1 tags ride alongside the ram read
    logic          p1_valid_reg, p1_skip_reg, p1_first_reg, p1_last_reg;
    logic [FW-1:0] p1_q_reg;
    logic          skip_hit;

    assign skip_hit = cmd.skip && (6'(edge_reg) < eff.degree) &&
                      (cmd.e == {1'b0, edge_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.rd_en;
        end
        p1_skip_reg  <= skip_hit;
        p1_first_reg <= cmd.first;
        p1_last_reg  <= cmd.last;
        p1_q_reg     <= cmd.q[FW-1:0];
    end

    // stage 2 accumulates one edge a cycle
    logic signed [SW-1:0] acc_reg, acc_next, term;
    logic signed [SW-1:0] sum_reg;
    logic                 p2_valid_reg;
    logic [FW-1:0]        p2_q_reg;

    always_comb begin
        term = p1_skip_reg ? '0 : SW'(signed'(msg_rdata));
        if (p1_first_reg) begin
            acc_next = SW'(signed'(ch_rdata)) + term;
        end else begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg && p1_last_reg;
        end
        if (p1_valid_reg) begin
            acc_reg <= acc_next;
        end
        if (p1_valid_reg && p1_last_reg) begin
            sum_reg  <= acc_next;
            p2_q_reg <= p1_q_reg;
        end
    end

    // stage 3: sorted insert and running maximum
    logic                 lv_reg   [MAX_LIST];
    logic signed [SW-1:0] lval_reg [MAX_LIST];
    logic [FW-1:0]        lsym_reg [MAX_LIST];
    logic                 lv_next  [MAX_LIST];
    logic signed [SW-1:0] lval_next[MAX_LIST];
    logic [FW-1:0]        lsym_next[MAX_LIST];
    logic signed [SW-1:0] best_val_reg;
    logic [FW-1:0]        best_sym_reg;

    always_comb begin
        int unsigned im1;
        logic keep, prev_ge;
        for (int unsigned i = 0; i < MAX_LIST; i++) begin
            im1     = (i == 0) ? 0 : i - 1;
            keep    = lv_reg[i] && (lval_reg[i] >= sum_reg);
            prev_ge = (i == 0) || (lv_reg[im1] && (lval_reg[im1] >= sum_reg));
            if (keep) begin
                lv_next[i]   = lv_reg[i];
                lval_next[i] = lval_reg[i];
                lsym_next[i] = lsym_reg[i];
            end else if (prev_ge) begin
                lv_next[i]   = 1'b1;
                lval_next[i] = sum_reg;
                lsym_next[i] = p2_q_reg;
            end else begin
                lv_next[i]   = lv_reg[im1];
                lval_next[i] = lval_reg[im1];
                lsym_next[i] = lsym_reg[im1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int unsigned i = 0; i < MAX_LIST; i++) begin
            if (!aresetn || cmd.clear) begin
                lv_reg[i] <= 1'b0;
            end else if (p2_valid_reg) begin
                lv_reg[i] <= lv_next[i];
            end
            if (p2_valid_reg) begin
                lval_reg[i] <= lval_next[i];
                lsym_reg[i] <= lsym_next[i];
            end
        end
        if (p2_valid_reg && ((p2_q_reg == '0) || (sum_reg > best_val_reg))) begin
            best_val_reg <= sum_reg;
            best_sym_reg <= p2_q_reg;
        end
    end

    // output register
    logic signed [SW-1:0] sel_val;
    logic [5:0]           sel_sym;
    logic [LW-1:0]        k_idx;

    assign k_idx = cmd.k[LW-1:0];

    always_comb begin
        case (cmd.op)
            nvn_pkg::OP_EMIT: begin
                sel_val = lval_reg[k_idx];
                sel_sym = 6'(lsym_reg[k_idx]);
            end
            nvn_pkg::OP_DECIDE: begin
                sel_val = best_val_reg;
                sel_sym = 6'(best_sym_reg);
            end
            default: begin
                sel_val = (32'(sym_reg) < MAX_FIELD) ? sum_reg : '0;
                sel_sym = sym_reg;
            end
        endcase
    end

    function automatic logic signed [nvn_pkg::LLR_W-1:0] sat_llr(
        input logic signed [SW-1:0] v
    );
        logic signed [31:0] w;
        w = 32'(v);
        if (w > 32'sd1048575) begin
            return 21'sd1048575;
        end else if (w < -32'sd1048576) begin
            return -21'sd1048576;
        end
        return 21'(w);
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_out_symbol <= sel_sym;
            m_out_llr    <= sat_llr(sel_val);
            m_last       <= cmd.out_last;
        end
    end

endmodule
